>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define FLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define FLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/flc_pkg.sv
package flc_pkg;

  localparam int MAX_TAPS    = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int VALUE_W     = 16;
  localparam int INDEX_W     = 4;
  localparam int TAPS_W      = 5;
  localparam int RESULT_W    = 36;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int LAT         = MAX_TAPS + 1;
  localparam int CNT_W       = $clog2(LAT + 1);
  localparam int TAIL_W      = $clog2(MAX_TAPS);
  localparam int ACT_W       = $clog2(MAX_TAPS + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [RESULT_W-1:0]    result_t;

  typedef enum logic {
    OP_COEF   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } chain_t;

  function automatic sample_t to_sample(logic [VALUE_W-1:0] v);
    sample_t s;
    s = '0;
    for (int i = 0; i < SAMPLE_BITS && i < VALUE_W; i++) begin
      s[i] = v[i];
    end
    return s;
  endfunction

endpackage

>>> rtl/flc_intf.sv
interface flc_in_if;
  import flc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [INDEX_W-1:0]        coeff_index;
  logic signed [VALUE_W-1:0] value;
  logic                      last_sample;
  modport source (output valid, op, coeff_index, value, last_sample, input ready);
  modport sink   (input valid, op, coeff_index, value, last_sample, output ready);
endinterface

interface flc_out_if;
  import flc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] result;
  logic                       last_result;
  modport source (output valid, result, last_result, input ready);
  modport sink   (input valid, result, last_result, output ready);
endinterface

interface flc_cfg_if;
  import flc_pkg::*;
  logic              valid;
  logic              ready;
  logic [TAPS_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/full_linear_convolution.sv
// A sample result passes the history register, the product stage and the sum chain, and
// is captured once the output slot is free; each tail result follows after the one before.
// A new sample is taken only once the last one and its tail are through, at a rate set by
// the product stage and the sum chain; one coefficient write per cycle while idle.
// Reset: asynchronous active low; clears coefficients, history and sums, taps_q = 1.
module full_linear_convolution (
  input  logic      clk_i,
  input  logic      rst_ni,
  flc_in_if.sink    in_i,
  flc_out_if.source out_o,
  flc_cfg_if.sink   cfg_i
);
  import flc_pkg::*;

  logic [TAPS_W-1:0] taps_q;
  logic [ACT_W-1:0]  act;
  chain_t            chain;
  sample_t           shift_in;
  logic              coef_wr;
  logic [MAX_TAPS-1:0] tap_en;
  logic [MAX_TAPS-1:0] coef_we;
  sample_t           x_link [MAX_TAPS];
  result_t           sum_link [MAX_TAPS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TAPS_W'(1);
    end else if (cfg_i.valid) begin
      taps_q <= cfg_i.data;
    end
  end

  always_comb begin
    if (taps_q == '0) begin
      act = ACT_W'(1);
    end else if (int'(taps_q) > MAX_TAPS) begin
      act = ACT_W'(MAX_TAPS);
    end else begin
      act = ACT_W'(taps_q);
    end
  end

  flc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .taps_i     (act),
    .sum_i      (sum_link[MAX_TAPS-1]),
    .chain_o    (chain),
    .shift_in_o (shift_in),
    .coef_wr_o  (coef_wr)
  );

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    sample_t x_in;
    result_t sum_in;

    assign tap_en[k]  = (ACT_W'(k) < act);
    assign coef_we[k] = coef_wr && (int'(in_i.coeff_index) == k);

    if (k == 0) begin : g_head
      assign x_in   = shift_in;
      assign sum_in = '0;
    end else begin : g_body
      assign x_in   = x_link[k-1];
      assign sum_in = sum_link[k-1];
    end

    flc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .chain_i   (chain),
      .coef_we_i (coef_we[k]),
      .coef_i    (to_sample(in_i.value)),
      .tap_en_i  (tap_en[k]),
      .x_i       (x_in),
      .x_o       (x_link[k]),
      .sum_i     (sum_in),
      .sum_o     (sum_link[k])
    );
  end

endmodule

>>> rtl/flc_cell.sv
module flc_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  flc_pkg::chain_t  chain_i,
  input  logic             coef_we_i,
  input  flc_pkg::sample_t coef_i,
  input  logic             tap_en_i,
  input  flc_pkg::sample_t x_i,
  output flc_pkg::sample_t x_o,
  input  flc_pkg::result_t sum_i,
  output flc_pkg::result_t sum_o
);
  import flc_pkg::*;

  sample_t                   coef_q;
  sample_t                   x_q;
  logic signed [PROD_W-1:0]  prod_q;
  result_t                   sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      x_q    <= '0;
      prod_q <= '0;
      sum_q  <= '0;
    end else begin
      if (coef_we_i) begin
        coef_q <= coef_i;
      end
      if (chain_i.clear) begin
        x_q <= '0;
      end else if (chain_i.shift) begin
        x_q <= x_i;
      end
      prod_q <= coef_q * x_q;
      sum_q  <= tap_en_i ? sum_i + RESULT_W'(prod_q) : sum_i;
    end
  end

  assign x_o   = x_q;
  assign sum_o = sum_q;

endmodule

>>> rtl/flc_ctrl.sv
`include "assert_macros.svh"

module flc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  flc_in_if.sink                   in_i,
  flc_out_if.source                out_o,
  input  logic [flc_pkg::ACT_W-1:0] taps_i,
  input  flc_pkg::result_t         sum_i,
  output flc_pkg::chain_t          chain_o,
  output flc_pkg::sample_t         shift_in_o,
  output logic                     coef_wr_o
);
  import flc_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TAIL_W-1:0] tails_q, tails_d;
  logic              last_q, last_d;
  logic              out_valid_q;
  result_t           res_q;
  logic              res_last_q;
  logic              slot_free;
  logic              cap;

  assign in_i.ready = (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || out_o.ready;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    tails_d    = tails_q;
    last_d     = last_q;
    chain_o    = '0;
    shift_in_o = '0;
    coef_wr_o  = 1'b0;
    cap        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.op == OP_SAMPLE) begin
            chain_o.shift = 1'b1;
            shift_in_o    = to_sample(in_i.value);
            tails_d       = in_i.last_sample ? TAIL_W'(taps_i - 1'b1) : '0;
            last_d        = in_i.last_sample;
            cnt_d         = '0;
            state_d       = ST_RUN;
          end else begin
            coef_wr_o = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (cnt_q != CNT_W'(LAT)) begin
          cnt_d = cnt_q + 1'b1;
        end else if (slot_free) begin
          cap = 1'b1;
          if (tails_q != '0) begin
            chain_o.shift = 1'b1;
            tails_d       = tails_q - 1'b1;
            cnt_d         = '0;
          end else begin
            chain_o.clear = last_q;
            state_d       = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tails_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tails_q <= tails_d;
      last_q  <= last_d;
      if (cap) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap) begin
      res_q      <= sum_i;
      res_last_q <= last_q && (tails_q == '0);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result      = res_q;
  assign out_o.last_result = res_last_q;

  `FLC_ASSERT_ALWAYS(a_shift_clear_excl, !(chain_o.shift && chain_o.clear), "shift and clear together")
  `FLC_ASSERT(a_tails_bound, (state_q == ST_RUN) |-> (tails_q < taps_i), "tail count out of range")
  `FLC_ASSERT(a_no_tail_mid, (state_q == ST_RUN && !last_q) |-> (tails_q == '0), "tail without last")
  `FLC_ASSERT(a_final_idle, (cap && tails_q == '0) |=> (state_q == ST_IDLE), "no return to idle")

endmodule

>>> sim/flc_checker.sv
`timescale 1ns / 1ps

module flc_checker (
  input  logic clk_i,
  input  logic rst_ni,
  flc_in_if    in_mon,
  flc_out_if   out_mon,
  flc_cfg_if   cfg_mon,
  output int   errors_o,
  output int   pending_o,
  output int   results_o
);
  import flc_pkg::*;

  typedef struct {
    result_t sum;
    logic    last;
  } conv_out_t;

  sample_t           kernel [MAX_TAPS];
  sample_t           history[MAX_TAPS-1];
  logic [TAPS_W-1:0] kernel_len;
  conv_out_t         expected_q[$];
  int                err_count;
  int                checked;

  function automatic void flag(string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  function automatic void convolve_sample(sample_t s, logic is_last);
    sample_t   win[MAX_TAPS];
    int        taps;
    longint    acc;
    conv_out_t o;
    win[0] = s;
    for (int k = 1; k < MAX_TAPS; k++) begin
      win[k] = history[k-1];
    end
    for (int k = MAX_TAPS - 1; k > 0; k--) begin
      history[k-1] = win[k-1];
    end
    taps = int'(kernel_len);
    if (taps < 1) taps = 1;
    if (taps > MAX_TAPS) taps = MAX_TAPS;
    // offset 0 is the regular output, the rest is the tail after a last sample
    for (int j = 0; j < (is_last ? taps : 1); j++) begin
      acc = 0;
      for (int k = j; k < taps; k++) begin
        acc += longint'(kernel[k]) * longint'(win[k-j]);
      end
      o.sum  = result_t'(acc);
      o.last = is_last && (j == taps - 1);
      expected_q.push_back(o);
    end
    if (is_last) begin
      foreach (history[i]) history[i] = '0;
    end
  endfunction

  always @(posedge clk_i) begin
    conv_out_t exp_out;
    if (!rst_ni) begin
      foreach (kernel[i]) kernel[i] = '0;
      foreach (history[i]) history[i] = '0;
      kernel_len = TAPS_W'(1);
      expected_q.delete();
      err_count = 0;
      checked = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        kernel_len = cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == OP_SAMPLE) begin
          convolve_sample(sample_t'(in_mon.value), in_mon.last_sample);
        end else if (in_mon.coeff_index < MAX_TAPS) begin
          kernel[in_mon.coeff_index] = sample_t'(in_mon.value);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (expected_q.size() == 0) begin
          flag($sformatf("result %0d: expected none, got result %0d last %0b",
                         checked, out_mon.result, out_mon.last_result));
        end else begin
          exp_out = expected_q.pop_front();
          if (out_mon.result !== exp_out.sum) begin
            flag($sformatf("result %0d: result expected %0d, got %0d",
                           checked, exp_out.sum, out_mon.result));
          end
          if (out_mon.last_result !== exp_out.last) begin
            flag($sformatf("result %0d: last_result expected %0b, got %0b",
                           checked, exp_out.last, out_mon.last_result));
          end
        end
      end
    end
    errors_o  <= err_count;
    pending_o <= expected_q.size();
    results_o <= checked;
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import flc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 2 * (MAX_TAPS + 3);
  localparam int ITEM_TARGET    = 250;

  localparam logic signed [VALUE_W-1:0] V_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] V_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_MOSTLY,
    RX_HALF,
    RX_SPARSE
  } rx_mode_e;

  logic     clk;
  logic     rst_n;
  int       errors;
  int       pending;
  int       results_checked;
  int       n_samples;
  int       n_coefs;
  int       n_cfg;
  int       burst_left;
  bit       gaps_on;
  logic     hold_req = 1'b0;
  logic     hold_ack;
  int       hold_left;
  int       rx_left;
  rx_mode_e rx_mode;
  int       idle_cycles;

  flc_in_if  in_if();
  flc_out_if out_if();
  flc_cfg_if cfg_if();

  full_linear_convolution dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  flc_checker checker_i (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_mon   (in_if),
    .out_mon  (out_if),
    .cfg_mon  (cfg_if),
    .errors_o (errors),
    .pending_o(pending),
    .results_o(results_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_ack     <= hold_req;
      hold_left    <= 0;
      rx_left      <= 0;
      rx_mode      <= RX_OPEN;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
        RX_HALF:   out_if.ready <= 1'($urandom_range(0, 1));
        default:   out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results still expected",
               WATCHDOG_LIMIT, pending);
      $display("FAIL full_linear_convolution");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return V_MIN;
      1:       return V_MAX;
      2:       return '0;
      3:       return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic send(op_e op, logic [INDEX_W-1:0] idx, logic signed [VALUE_W-1:0] val,
                      logic is_last);
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.coeff_index <= idx;
    in_if.value       <= val;
    in_if.last_sample <= is_last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (op == OP_SAMPLE) n_samples++;
    else n_coefs++;
    if (gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // drop valid and wait until every expected result has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_taps(logic [TAPS_W-1:0] taps);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= taps;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic send_signal(bit terminate);
    int len;
    logic is_last;
    repeat ($urandom_range(0, 4)) begin
      send(OP_COEF, INDEX_W'($urandom), pick_value(), 1'($urandom));
    end
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 14) == 0) begin
        send(OP_COEF, INDEX_W'($urandom), pick_value(), 1'($urandom));
      end
      if (i == len - 1) is_last = terminate;
      else is_last = ($urandom_range(0, 24) == 0);
      send(OP_SAMPLE, INDEX_W'($urandom), pick_value(), is_last);
    end
  endtask

  initial begin
    logic [TAPS_W-1:0] taps;
    int phase;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.op          <= OP_COEF;
    in_if.coeff_index <= '0;
    in_if.value       <= '0;
    in_if.last_sample <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.data       <= '0;
    n_samples  = 0;
    n_coefs    = 0;
    n_cfg      = 0;
    burst_left = 0;
    gaps_on    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // starts on the reset kernel (one tap, all coefficients zero), then writes coefficient 0
    send(OP_SAMPLE, '0, V_MAX, 1'b0);
    send(OP_COEF, '0, V_MIN, 1'b1);
    send(OP_SAMPLE, '1, V_MIN, 1'b1);
    send(OP_SAMPLE, '0, V_MAX, 1'b0);
    drain();
    write_taps(TAPS_W'(MAX_TAPS));
    send(OP_COEF, '1, V_MIN, 1'b0);
    send(OP_COEF, INDEX_W'(7), V_MAX, 1'b0);
    send(OP_SAMPLE, '0, V_MIN, 1'b0);
    send(OP_SAMPLE, '0, V_MAX, 1'b0);
    send(OP_COEF, INDEX_W'(7), '1, 1'b0);
    send(OP_SAMPLE, '0, '0, 1'b1);
    drain();
    write_taps('0);
    send(OP_SAMPLE, '0, V_MIN, 1'b1);
    drain();
    write_taps('1);
    send(OP_SAMPLE, '0, V_MIN, 1'b0);
    send(OP_SAMPLE, '0, V_MIN, 1'b1);
    drain();
    write_taps(TAPS_W'(3));
    send(OP_SAMPLE, '0, VALUE_W'(1234), 1'b0);
    send(OP_SAMPLE, '0, V_MAX, 1'b0);
    drain();
    write_taps(TAPS_W'(9));
    send(OP_SAMPLE, '0, V_MIN, 1'b1);
    drain();

    phase = 0;
    while (n_samples + n_coefs < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       taps = '0;
        1:       taps = '1;
        2:       taps = TAPS_W'(MAX_TAPS);
        3:       taps = TAPS_W'($urandom_range(1, MAX_TAPS));
        default: taps = TAPS_W'($urandom_range(1, 6));
      endcase
      write_taps(taps);
      gaps_on = (phase % 4 != 1);
      if (phase == 2) begin
        gaps_on = 1'b0;
        hold_req <= ~hold_req;
      end
      repeat ($urandom_range(2, 4)) send_signal($urandom_range(0, 7) != 0);
      drain();
      phase++;
    end

    write_taps(TAPS_W'(MAX_TAPS));
    gaps_on = 1'b1;
    send_signal(1'b1);
    drain();

    $display("covered %0d samples and %0d coefficient writes over %0d kernel lengths",
             n_samples, n_coefs, n_cfg);
    $display("%0d results checked, %0d mismatches, %0d still expected",
             results_checked, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("PASS full_linear_convolution");
    end else begin
      $display("FAIL full_linear_convolution");
    end
    $finish;
  end

endmodule
